// ===== sv/eqd_pkg.sv =====
package eqd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam int PAYLOAD_BYTES_DEFAULT = 8;

   typedef enum logic [1:0] {
      OP_PUT      = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_START    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  handler_id;
      logic [7:0]  payload_length;
      logic [63:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_handler_id;
      logic [3:0]  out_length;
      logic [63:0] out_payload;
      logic        pending;
      logic [4:0]  occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  handler;
      logic [3:0]  length;
      logic [63:0] bytes;
   } entry_type;

   function automatic logic [63:0] byte_mask(input logic [3:0] len);
      logic [63:0] mask;
      mask = '0;
      for (int b = 0; b < 8; b++) begin
         mask[8*b +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

// ===== sv/event_queue_dispatcher_unit.sv =====
// Event queue dispatcher: a circular queue of pending events held in one
// synchronous memory. A request word is taken at a rising edge where start
// is high and busy is low. Its operation is a put, a dispatch of the oldest
// event, or a start of the running flag.
// Every request gives exactly one response word on rsp_word, shown for one
// cycle while rsp_valid is high. A put, a start, an unused code or a
// dispatch on an empty queue answers in the cycle after acceptance and lets
// the next request in at once, so these run at one word per cycle.
// A dispatch that finds an event reads it from the memory into a read
// register; busy is high while the unit waits for that read, and the
// response is then registered from the read data, so no word is taken meanwhile.
// The response carries the pending flag and the occupancy after the word.
// Reset clears the indices, the count, and the running and pending flags;
// the memory contents are not cleared and need not be, since only entries
// that were written are ever read. The receiver cannot stall: each
// response is taken in the cycle it is shown.
module event_queue_dispatcher_unit #(
   parameter int QUEUE_DEPTH   = eqd_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PAYLOAD_BYTES = eqd_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  eqd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output eqd_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      read_index_ff, read_index_in;
   logic [IDX_W-1:0]      write_index_ff, write_index_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  running_ff, running_in;
   logic                  pending_ff, pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   eqd_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   eqd_pkg::entry_type    mem [QUEUE_DEPTH];
   eqd_pkg::entry_type    rd_data_ff;
   eqd_pkg::entry_type    wr_data;
   logic                  wr_en;

   logic [IDX_W-1:0]      read_next;
   logic [IDX_W-1:0]      write_next;

   assign read_next  = (read_index_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : read_index_ff + 1'b1;
   assign write_next = (write_index_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : write_index_ff + 1'b1;

   assign wr_data.handler = req_word.handler_id;
   assign wr_data.length  = req_word.payload_length[3:0];
   assign wr_data.bytes   = req_word.payload
                            & eqd_pkg::byte_mask(req_word.payload_length[3:0]);

   always_comb begin
      state_in       = state_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      count_in       = count_ff;
      running_in     = running_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = 1'b0;
      rsp_word_in    = '0;
      wr_en          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_word.operation)
                  eqd_pkg::OP_PUT: begin
                     rsp_valid_in = 1'b1;
                     if (req_word.payload_length > 8'(PAYLOAD_BYTES)) begin
                        rsp_word_in.status = eqd_pkg::ST_RANGE;
                     end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_word_in.status = eqd_pkg::ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        count_in       = count_ff + 1'b1;
                        write_index_in = write_next;
                        if (running_ff) begin
                           pending_in = 1'b1;
                        end
                     end
                  end
                  eqd_pkg::OP_DISPATCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_word_in.status = eqd_pkg::ST_EMPTY;
                        pending_in         = 1'b0;
                     end else begin
                        count_in      = count_ff - 1'b1;
                        read_index_in = read_next;
                        state_in      = S_FETCH;
                     end
                  end
                  eqd_pkg::OP_START: begin
                     rsp_valid_in = 1'b1;
                     running_in   = 1'b1;
                     if (count_ff != '0) begin
                        pending_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH: begin
            rsp_valid_in               = 1'b1;
            rsp_word_in.status         = eqd_pkg::ST_OK;
            rsp_word_in.out_handler_id = rd_data_ff.handler;
            rsp_word_in.out_length     = rd_data_ff.length;
            rsp_word_in.out_payload    = rd_data_ff.bytes;
            state_in                   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_word_in.pending   = pending_in;
      rsp_word_in.occupancy = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         read_index_ff  <= '0;
         write_index_ff <= '0;
         count_ff       <= '0;
         running_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         count_ff       <= count_in;
         running_ff     <= running_in;
         pending_ff     <= pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[write_index_ff] <= wr_data;
      end
      rd_data_ff <= mem[read_index_ff];
   end

   assign busy      = (state_ff == S_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== sv/eqd_checker.sv =====
module eqd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input eqd_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input eqd_pkg::rsp_word_type rsp_word
);

   logic accept;
   assign accept = start && !busy;

   a_non_dispatch_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.operation != eqd_pkg::OP_DISPATCH) |=> rsp_valid && !busy)
      else $error("A word other than a dispatch did not answer in the next cycle.");

   a_dispatch_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.operation == eqd_pkg::OP_DISPATCH)
      |=> (rsp_valid && (rsp_word.status == eqd_pkg::ST_EMPTY)) || (busy && !rsp_valid))
      else $error("A dispatch neither answered empty nor fetched an event.");

   a_no_spurious_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept) || $past(busy))
      else $error("A response appeared without a word to cause it.");

   a_empty_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == eqd_pkg::ST_EMPTY)
      |-> !rsp_word.pending && (rsp_word.occupancy == '0) && (rsp_word.out_payload == '0))
      else $error("An empty dispatch left pending or occupancy set.");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_word.status == eqd_pkg::ST_RANGE)
                    || (rsp_word.status == eqd_pkg::ST_FULL))
      |-> (rsp_word.out_handler_id == '0) && (rsp_word.out_length == '0))
      else $error("A rejected put returned event fields.");

endmodule

bind event_queue_dispatcher_unit eqd_checker u_eqd_checker (.*);
